FILE: hw/rtl/sidc_pkg.sv
// Package: shared types and constants for the switch input debounce block.
`timescale 1ns / 1ps

package sidc_pkg;

    localparam int CHANNELS_DEF = 4;   // default channel count
    localparam int MAX_CHANNELS = 8;   // connect/polarity masks are 8 bits wide
    localparam int PIN_W        = 4;   // physical pins per word
    localparam int OUT_W        = 4;   // status and change bits per result word
    localparam int ACTION_W     = 2;
    localparam int PORTS_W      = 3;
    localparam int MASK_W       = 8;
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;

    localparam logic [1:0]         FILTER_MAX      = 2'd3;  // three equal repeats
    localparam logic [1:0]         VALID_MAX       = 2'd2;
    localparam logic [PORTS_W-1:0] PORTS_RESET     = 3'd4;
    localparam logic [MASK_W-1:0]  CONNECT_RESET   = 8'h00;
    localparam logic [MASK_W-1:0]  POLARITY_RESET  = 8'h00;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_INIT   = 2'd1,
        ACT_CLEAR  = 2'd2
    } action_t;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_ACTIVE_PORTS  = 2'd0,
        REG_CONNECT_MASK  = 2'd1,
        REG_POLARITY_MASK = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [PORTS_W-1:0] active_ports;
        logic [MASK_W-1:0]  connect_mask;
        logic [MASK_W-1:0]  polarity_mask;
    } cfg_t;

endpackage

FILE: hw/rtl/sidc_if.sv
// Interfaces: input word channel and result word channel.
`timescale 1ns / 1ps

interface sidc_in_if;
    import sidc_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [PIN_W-1:0]    pin_levels;

    modport source (output valid, output action, output pin_levels, input ready);
    modport sink   (input valid, input action, input pin_levels, output ready);
endinterface

interface sidc_out_if;
    import sidc_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] status_bits;
    logic [OUT_W-1:0] change_flags;
    logic             event_pulse;
    logic             updated;

    modport source (output valid, output status_bits, output change_flags,
                    output event_pulse, output updated, input ready);
    modport sink   (input valid, input status_bits, input change_flags,
                    input event_pulse, input updated, output ready);
endinterface

FILE: hw/rtl/switch_input_debounce_change_detect_top.sv
// Top level: multi-channel switch debounce with status and sticky change flags.
`timescale 1ns / 1ps
//
// Usage
//   samples : input words {action, pin_levels}. action SAMPLE runs one debounce
//             tick, INIT loads status from the pins and clears change flags,
//             CLEAR clears the change flags only; the fourth code is a no-op.
//             A pin low means the switch is closed (active).
//   results : one result word per input word: status_bits, change_flags,
//             event_pulse (a status change was seen on this tick) and updated
//             (every channel in use was stable, so status was re-evaluated).
//   APB     : active_ports at 0x0, connect_mask at 0x4, polarity_mask at 0x8.
//             Write only while no word is in flight; pready is tied high.
// Timing
//   Two register stages: input register, then the result register, which is
//   loaded together with the per-channel state. One word per cycle sustained
//   while results.ready is high; the only loop is the per-channel state
//   update per word.
// Reset
//   rst_n clears all channel state (levels, counters, status, flags) and
//   loads the register defaults: 4 ports, connect and polarity masks 0.
// Stall
//   When results.ready is low the result word holds, the input register
//   fills, and samples.ready drops until the result word is taken.

module switch_input_debounce_change_detect_top #(
    parameter int CHANNELS = sidc_pkg::CHANNELS_DEF   // 1..8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    sidc_in_if.sink                           samples,
    sidc_out_if.source                        results,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sidc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [sidc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sidc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import sidc_pkg::*;

    cfg_t cfg;

    sidc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ---------------- handshake ----------------
    logic                s1_valid_reg;
    logic [ACTION_W-1:0] s1_action_reg;
    logic [PIN_W-1:0]    s1_pins_reg;
    logic                out_valid_reg;
    logic                out_free;   // result register can take a word
    logic                fire;       // input register word processed this cycle

    assign out_free      = !out_valid_reg || results.ready;
    assign fire          = s1_valid_reg && out_free;
    assign samples.ready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (samples.ready)
                s1_valid_reg <= samples.valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            s1_action_reg <= samples.action;
            s1_pins_reg   <= samples.pin_levels;
        end
    end

    // ---------------- channel logic ----------------
    action_t act_code;
    assign act_code = action_t'(s1_action_reg);

    // channels in use: active_ports clamped to CHANNELS
    logic [3:0] ports4;
    logic [3:0] n_use;
    assign ports4 = {1'b0, cfg.active_ports};
    assign n_use  = (ports4 > 4'(CHANNELS)) ? 4'(CHANNELS) : ports4;

    logic [CHANNELS-1:0] lvl_reg, lvl_next;
    logic [CHANNELS-1:0] stat_reg, stat_next;
    logic [CHANNELS-1:0] chg_reg, chg_next;
    logic [1:0]          filt_reg  [CHANNELS];
    logic [1:0]          filt_next [CHANNELS];
    logic [1:0]          vcnt_reg  [CHANNELS];
    logic [1:0]          vcnt_next [CHANNELS];
    logic [CHANNELS-1:0] in_use;
    logic [CHANNELS-1:0] stable;
    logic [CHANNELS-1:0] evt_bits;
    logic                all_stable;

    // with no channel in use this is 1: the tick updates trivially
    assign all_stable = &(stable | ~in_use);

    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_chan
        logic act;    // debounce input: closed switch reads 1
        logic conn;
        logic keep;   // polarity: 1 keeps, 0 inverts
        logic qual;   // masked, polarity-corrected level
        logic [1:0] vinc;

        if (g < PIN_W)
        begin : g_pin
            assign act = ~s1_pins_reg[g];
        end
        else
        begin : g_nopin
            assign act = 1'b0;   // no pin: reads open
        end

        assign in_use[g] = (4'(g) < n_use);
        assign conn      = cfg.connect_mask[MAX_CHANNELS-1-g];
        assign keep      = cfg.polarity_mask[MAX_CHANNELS-1-g];
        assign qual      = conn & (act ^ ~keep);
        assign stable[g] = (act == lvl_reg[g]) && (filt_reg[g] == FILTER_MAX);
        assign vinc      = (vcnt_reg[g] == VALID_MAX) ? VALID_MAX : vcnt_reg[g] + 2'd1;

        always_comb
        begin
            lvl_next[g]  = lvl_reg[g];
            filt_next[g] = filt_reg[g];
            vcnt_next[g] = vcnt_reg[g];
            stat_next[g] = stat_reg[g];
            chg_next[g]  = chg_reg[g];
            evt_bits[g]  = 1'b0;
            if (in_use[g])
            begin
                case (act_code)
                    ACT_SAMPLE:
                    begin
                        if (act != lvl_reg[g])
                        begin
                            lvl_next[g]  = act;
                            filt_next[g] = 2'd0;
                        end
                        else if (filt_reg[g] != FILTER_MAX)
                        begin
                            filt_next[g] = filt_reg[g] + 2'd1;
                        end
                        if (all_stable)
                        begin
                            stat_next[g] = qual;
                            if (!conn)
                            begin
                                // counters cleared, then this tick counts once
                                filt_next[g] = 2'd0;
                                vcnt_next[g] = 2'd1;
                            end
                            else
                            begin
                                vcnt_next[g] = vinc;
                                if ((vinc == VALID_MAX) && (stat_reg[g] != qual))
                                begin
                                    chg_next[g] = 1'b1;
                                    evt_bits[g] = 1'b1;
                                end
                            end
                        end
                    end
                    ACT_INIT:
                    begin
                        stat_next[g] = qual;
                        chg_next[g]  = 1'b0;
                    end
                    ACT_CLEAR:
                    begin
                        chg_next[g] = 1'b0;
                    end
                    default: ;
                endcase
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                lvl_reg[g]  <= 1'b0;
                filt_reg[g] <= 2'd0;
                vcnt_reg[g] <= 2'd0;
                stat_reg[g] <= 1'b0;
                chg_reg[g]  <= 1'b0;
            end
            else if (fire)
            begin
                lvl_reg[g]  <= lvl_next[g];
                filt_reg[g] <= filt_next[g];
                vcnt_reg[g] <= vcnt_next[g];
                stat_reg[g] <= stat_next[g];
                chg_reg[g]  <= chg_next[g];
            end
        end
    end

    // only channels 0..3 show in the result word
    logic [OUT_W-1:0] stat_out, chg_out;
    for (genvar b = 0; b < OUT_W; b++)
    begin : g_out
        if (b < CHANNELS)
        begin : g_used
            assign stat_out[b] = stat_next[b];
            assign chg_out[b]  = chg_next[b];
        end
        else
        begin : g_unused
            assign stat_out[b] = 1'b0;
            assign chg_out[b]  = 1'b0;
        end
    end

    // ---------------- result register ----------------
    logic [OUT_W-1:0] status_out_reg;
    logic [OUT_W-1:0] change_out_reg;
    logic             event_out_reg;
    logic             updated_out_reg;

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_out_reg  <= stat_out;
            change_out_reg  <= chg_out;
            event_out_reg   <= |evt_bits;
            updated_out_reg <= (act_code == ACT_SAMPLE) && all_stable;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.status_bits  = status_out_reg;
    assign results.change_flags = change_out_reg;
    assign results.event_pulse  = event_out_reg;
    assign results.updated      = updated_out_reg;

endmodule

FILE: hw/rtl/sidc_regs.sv
// APB configuration registers: active port count, connect and polarity masks.
`timescale 1ns / 1ps

module sidc_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sidc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [sidc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sidc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output sidc_pkg::cfg_t                     cfg
);
    import sidc_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_ports  <= PORTS_RESET;
            cfg_reg.connect_mask  <= CONNECT_RESET;
            cfg_reg.polarity_mask <= POLARITY_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_ACTIVE_PORTS:  cfg_reg.active_ports  <= pwdata[PORTS_W-1:0];
                REG_CONNECT_MASK:  cfg_reg.connect_mask  <= pwdata[MASK_W-1:0];
                REG_POLARITY_MASK: cfg_reg.polarity_mask <= pwdata[MASK_W-1:0];
                default: ;  // unmapped address, write dropped
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ACTIVE_PORTS:  prdata = APB_DATA_W'(cfg_reg.active_ports);
            REG_CONNECT_MASK:  prdata = APB_DATA_W'(cfg_reg.connect_mask);
            REG_POLARITY_MASK: prdata = APB_DATA_W'(cfg_reg.polarity_mask);
            default:           prdata = '0;
        endcase
    end

endmodule
